FILE: design/cdsr_pkg.sv
// Shared types and constants of the coprocessor DMA status register block.
`timescale 1ns / 1ps

package cdsr_pkg;

  typedef enum logic [1:0] {
    CMD_READ      = 2'd0,
    CMD_WRITE     = 2'd1,
    CMD_DMA_DONE  = 2'd2,
    CMD_TASK_DONE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_MEM_ADDR  = 3'd0,
    REG_DRAM_ADDR = 3'd1,
    REG_RD_LEN    = 3'd2,
    REG_WR_LEN    = 3'd3,
    REG_STATUS    = 3'd4,
    REG_FULL      = 3'd5,
    REG_BUSY      = 3'd6,
    REG_SEMAPHORE = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_UPD,
    ST_OUT
  } state_e;

  localparam int StatusW = 15;

  // Status bit positions.
  localparam int SbHalt   = 0;
  localparam int SbBroke  = 1;
  localparam int SbBusy   = 2;
  localparam int SbFull   = 3;
  localparam int SbSstep  = 5;
  localparam int SbIbreak = 6;
  localparam int SbSig0   = 7;
  localparam int SbTdone  = 9;
  localparam int NumSig   = 8;

  localparam logic [31:0]        LenReset    = 32'h0000_0ff8;
  localparam logic [StatusW-1:0] StatusReset = 15'h0001;

  // One queued transfer.
  typedef struct packed {
    logic        to_local;
    logic [31:0] len_word;
    logic [31:0] laddr;
    logic [31:0] eaddr;
  } queue_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic mul;
    logic upd;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start;
  } dp_sts_t;

endpackage

FILE: design/cdsr_ctrl.sv
// Sequencing state machine of the coprocessor DMA status register block.
`timescale 1ns / 1ps

module cdsr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  cdsr_pkg::dp_sts_t sts_i,
  output cdsr_pkg::dp_cmd_t cmd_o
);

  cdsr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdsr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cdsr_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = cdsr_pkg::ST_EXEC;
      end
      cdsr_pkg::ST_EXEC: begin
        state_d = sts_i.start ? cdsr_pkg::ST_MUL : cdsr_pkg::ST_OUT;
      end
      cdsr_pkg::ST_MUL: state_d = cdsr_pkg::ST_UPD;
      cdsr_pkg::ST_UPD: state_d = cdsr_pkg::ST_OUT;
      cdsr_pkg::ST_OUT: begin
        if (!out_stall_i) state_d = cdsr_pkg::ST_IDLE;
      end
      default: state_d = cdsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      cdsr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      cdsr_pkg::ST_EXEC: cmd_o.exec = 1'b1;
      cdsr_pkg::ST_MUL:  cmd_o.mul  = 1'b1;
      cdsr_pkg::ST_UPD:  cmd_o.upd  = 1'b1;
      cdsr_pkg::ST_OUT:  out_valid_o = 1'b1;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  a_mul_then_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cdsr_pkg::ST_MUL |=> state_q == cdsr_pkg::ST_UPD)
    else $error("address update did not follow multiply");

  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result is pending");

endmodule

FILE: design/cdsr_dp.sv
// Register file, transfer queue and descriptor datapath of the DMA status block.
`timescale 1ns / 1ps

module cdsr_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cdsr_pkg::dp_cmd_t cmd_i,
  output cdsr_pkg::dp_sts_t sts_o,
  input  logic [1:0]        cmd_in_i,
  input  logic [2:0]        reg_index_i,
  input  logic [31:0]       wdata_i,
  input  logic [31:0]       wmask_i,
  output logic [31:0]       rdata_o,
  output logic              dma_start_o,
  output logic              dma_to_local_o,
  output logic [12:0]       dma_local_addr_o,
  output logic [23:0]       dma_dram_addr_o,
  output logic [12:0]       dma_row_bytes_o,
  output logic [8:0]        dma_rows_o,
  output logic [11:0]       dma_row_skip_o,
  output logic              irq_raise_o,
  output logic              irq_clear_o
);

  function automatic logic pair_apply(logic cur, logic [1:0] p);
    logic r;
    r = cur;
    if (p == 2'b01) r = 1'b0;
    if (p == 2'b10) r = 1'b1;
    return r;
  endfunction

  // Architectural registers.
  logic [31:0] laddr_q, laddr_d, eaddr_q, eaddr_d;
  logic [31:0] rd_len_q, rd_len_d, wr_len_q, wr_len_d;
  logic [cdsr_pkg::StatusW-1:0] status_q, status_d;
  logic full_q, full_d, busy_q, busy_d, sem_q, sem_d;

  // Queue entries and latched transaction.
  cdsr_pkg::queue_entry_t ent0_q, ent0_d, ent1_q, ent1_d;
  cdsr_pkg::cmd_e cmd_q;
  cdsr_pkg::reg_e reg_q;
  logic [31:0] wdata_q, wmask_q;

  // Result registers and products.
  logic [31:0] rdata_q, rdata_d;
  logic        start_q, start_d, to_local_q, to_local_d;
  logic [12:0] loc_q, loc_d, row_bytes_q, row_bytes_d;
  logic [23:0] dram_q, dram_d;
  logic [8:0]  rows_q, rows_d;
  logic [11:0] skip_q, skip_d;
  logic        irq_raise_q, irq_raise_d, irq_clear_q, irq_clear_d;
  logic [21:0] prod_l_q, prod_l_d;
  logic [23:0] prod_e_q, prod_e_d;

  logic [31:0] w_st, masked_v;
  logic        push, begin_xfer;
  logic [13:0] span;
  cdsr_pkg::queue_entry_t new_ent, src;

  assign w_st     = wdata_q & wmask_q;
  assign span     = {1'b0, row_bytes_q} + {2'b00, skip_q};

  always_comb begin
    laddr_d     = laddr_q;
    eaddr_d     = eaddr_q;
    rd_len_d    = rd_len_q;
    wr_len_d    = wr_len_q;
    status_d    = status_q;
    full_d      = full_q;
    busy_d      = busy_q;
    sem_d       = sem_q;
    ent0_d      = ent0_q;
    ent1_d      = ent1_q;
    rdata_d     = rdata_q;
    start_d     = start_q;
    to_local_d  = to_local_q;
    loc_d       = loc_q;
    dram_d      = dram_q;
    row_bytes_d = row_bytes_q;
    rows_d      = rows_q;
    skip_d      = skip_q;
    irq_raise_d = irq_raise_q;
    irq_clear_d = irq_clear_q;
    prod_l_d    = prod_l_q;
    prod_e_d    = prod_e_q;
    push        = 1'b0;
    begin_xfer  = 1'b0;
    masked_v    = '0;
    new_ent     = '0;
    src         = ent1_q;

    if (cmd_i.exec) begin
      rdata_d     = '0;
      start_d     = 1'b0;
      to_local_d  = 1'b0;
      loc_d       = '0;
      dram_d      = '0;
      row_bytes_d = '0;
      rows_d      = '0;
      skip_d      = '0;
      irq_raise_d = 1'b0;
      irq_clear_d = 1'b0;
      new_ent.laddr = laddr_q;
      new_ent.eaddr = eaddr_q;

      case (cmd_q)
        cdsr_pkg::CMD_READ: begin
          case (reg_q)
            cdsr_pkg::REG_MEM_ADDR:  rdata_d = laddr_q;
            cdsr_pkg::REG_DRAM_ADDR: rdata_d = eaddr_q;
            cdsr_pkg::REG_RD_LEN:    rdata_d = rd_len_q;
            cdsr_pkg::REG_WR_LEN:    rdata_d = wr_len_q;
            cdsr_pkg::REG_STATUS:    rdata_d = {17'b0, status_q};
            cdsr_pkg::REG_FULL:      rdata_d = {31'b0, full_q};
            cdsr_pkg::REG_BUSY:      rdata_d = {31'b0, busy_q};
            cdsr_pkg::REG_SEMAPHORE: begin
              rdata_d = {31'b0, sem_q};
              sem_d   = 1'b1;
            end
            default: rdata_d = '0;
          endcase
        end
        cdsr_pkg::CMD_WRITE: begin
          case (reg_q)
            cdsr_pkg::REG_MEM_ADDR: begin
              laddr_d = (laddr_q & ~wmask_q) | (wdata_q & wmask_q);
            end
            cdsr_pkg::REG_DRAM_ADDR: begin
              eaddr_d = (eaddr_q & ~wmask_q) | (wdata_q & wmask_q);
            end
            cdsr_pkg::REG_RD_LEN: begin
              masked_v         = (rd_len_q & ~wmask_q) | (wdata_q & wmask_q);
              rd_len_d         = masked_v;
              push             = 1'b1;
              new_ent.to_local = 1'b1;
              new_ent.len_word = masked_v;
            end
            cdsr_pkg::REG_WR_LEN: begin
              masked_v         = (wr_len_q & ~wmask_q) | (wdata_q & wmask_q);
              wr_len_d         = masked_v;
              push             = 1'b1;
              new_ent.to_local = 1'b0;
              new_ent.len_word = masked_v;
            end
            cdsr_pkg::REG_STATUS: begin
              status_d[cdsr_pkg::SbHalt] =
                pair_apply(status_q[cdsr_pkg::SbHalt], w_st[1:0]);
              if (w_st[2]) status_d[cdsr_pkg::SbBroke] = 1'b0;
              irq_clear_d = (w_st[4:3] == 2'b01);
              irq_raise_d = (w_st[4:3] == 2'b10);
              status_d[cdsr_pkg::SbSstep] =
                pair_apply(status_q[cdsr_pkg::SbSstep], w_st[6:5]);
              status_d[cdsr_pkg::SbIbreak] =
                pair_apply(status_q[cdsr_pkg::SbIbreak], w_st[8:7]);
              for (int k = 0; k < cdsr_pkg::NumSig; k++) begin
                status_d[cdsr_pkg::SbSig0 + k] =
                  pair_apply(status_q[cdsr_pkg::SbSig0 + k], w_st[9 + 2 * k +: 2]);
              end
            end
            cdsr_pkg::REG_SEMAPHORE: sem_d = 1'b0;
            default: begin
              sem_d = sem_q;
            end
          endcase
        end
        cdsr_pkg::CMD_DMA_DONE: begin
          if (full_q) begin
            ent0_d                     = ent1_q;
            full_d                     = 1'b0;
            status_d[cdsr_pkg::SbFull] = 1'b0;
            begin_xfer                 = 1'b1;
            src                        = ent1_q;
          end else begin
            busy_d                     = 1'b0;
            status_d[cdsr_pkg::SbBusy] = 1'b0;
          end
        end
        cdsr_pkg::CMD_TASK_DONE: begin
          status_d[cdsr_pkg::SbHalt]  = 1'b1;
          status_d[cdsr_pkg::SbBroke] = 1'b1;
          status_d[cdsr_pkg::SbTdone] = 1'b1;
          irq_raise_d                 = status_q[cdsr_pkg::SbIbreak];
        end
        default: begin
          rdata_d = '0;
        end
      endcase

      if (push && !full_q) begin
        if (busy_q) begin
          ent1_d                     = new_ent;
          full_d                     = 1'b1;
          status_d[cdsr_pkg::SbFull] = 1'b1;
        end else begin
          ent0_d                     = new_ent;
          busy_d                     = 1'b1;
          status_d[cdsr_pkg::SbBusy] = 1'b1;
          begin_xfer                 = 1'b1;
          src                        = new_ent;
        end
      end

      if (begin_xfer) begin
        start_d     = 1'b1;
        to_local_d  = src.to_local;
        loc_d       = {src.laddr[12:3], 3'b000};
        dram_d      = {src.eaddr[23:3], 3'b000};
        row_bytes_d = {1'b0, src.len_word[11:3], 3'b111} + 13'd1;
        rows_d      = {1'b0, src.len_word[19:12]} + 9'd1;
        skip_d      = src.len_word[31:20];
        rd_len_d    = cdsr_pkg::LenReset;
      end
    end

    if (cmd_i.mul) begin
      prod_l_d = {13'b0, rows_q} * {9'b0, row_bytes_q};
      prod_e_d = {15'b0, rows_q} * {10'b0, span};
    end

    if (cmd_i.upd) begin
      laddr_d = {20'b0, {loc_q[11:3], 3'b000} + prod_l_q[11:0]};
      eaddr_d = {8'b0, dram_q + prod_e_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      laddr_q  <= '0;
      eaddr_q  <= '0;
      rd_len_q <= cdsr_pkg::LenReset;
      wr_len_q <= cdsr_pkg::LenReset;
      status_q <= cdsr_pkg::StatusReset;
      full_q   <= 1'b0;
      busy_q   <= 1'b0;
      sem_q    <= 1'b0;
    end else begin
      laddr_q  <= laddr_d;
      eaddr_q  <= eaddr_d;
      rd_len_q <= rd_len_d;
      wr_len_q <= wr_len_d;
      status_q <= status_d;
      full_q   <= full_d;
      busy_q   <= busy_d;
      sem_q    <= sem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= cdsr_pkg::cmd_e'(cmd_in_i);
      reg_q   <= cdsr_pkg::reg_e'(reg_index_i);
      wdata_q <= wdata_i;
      wmask_q <= wmask_i;
    end
    ent0_q      <= ent0_d;
    ent1_q      <= ent1_d;
    rdata_q     <= rdata_d;
    start_q     <= start_d;
    to_local_q  <= to_local_d;
    loc_q       <= loc_d;
    dram_q      <= dram_d;
    row_bytes_q <= row_bytes_d;
    rows_q      <= rows_d;
    skip_q      <= skip_d;
    irq_raise_q <= irq_raise_d;
    irq_clear_q <= irq_clear_d;
    prod_l_q    <= prod_l_d;
    prod_e_q    <= prod_e_d;
  end

  assign sts_o.start      = begin_xfer;
  assign rdata_o          = rdata_q;
  assign dma_start_o      = start_q;
  assign dma_to_local_o   = to_local_q;
  assign dma_local_addr_o = loc_q;
  assign dma_dram_addr_o  = dram_q;
  assign dma_row_bytes_o  = row_bytes_q;
  assign dma_rows_o       = rows_q;
  assign dma_row_skip_o   = skip_q;
  assign irq_raise_o      = irq_raise_q;
  assign irq_clear_o      = irq_clear_q;

  a_full_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> busy_q)
    else $error("queue full without busy");

  a_status_tracks_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q[cdsr_pkg::SbBusy] == busy_q && status_q[cdsr_pkg::SbFull] == full_q)
    else $error("status queue bits disagree with queue flags");

  a_descriptor_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul |-> start_q && rows_q != 9'd0 && row_bytes_q[2:0] == 3'b000)
    else $error("multiply step without a well-formed descriptor");

endmodule

FILE: design/coprocessor_dma_status_registers.sv
// Top level of the coprocessor DMA status register block.
`timescale 1ns / 1ps

// Register front end of a signal-processor DMA engine. Each input transaction
// is one bus read, one masked bus write, a dma-done event or a task-finished
// event, and it yields exactly one output transaction carrying the read data,
// an optional transfer descriptor and interrupt raise/clear pulses. The block
// works on one transaction at a time: it takes the transaction, executes it in
// the next cycle and, if it starts no transfer, presents the result in the
// cycle after; one that starts a transfer first has its end-of-transfer
// addresses computed through a registered multiply step followed by an add
// step. The result is held while out_stall_i is high. in_stall_o is low only
// while the block is empty. Writing a length register queues a transfer in a
// two-entry queue; a third one while the queue is full is dropped, though the
// length register still takes the write. When a transfer starts, dma_start_o
// is set and the descriptor fields hold the direction, local and external
// start addresses, row size rounded up to 8 bytes, row count and row skip;
// they are zero otherwise.
module coprocessor_dma_status_registers (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [2:0]  reg_index_i,
  input  logic [31:0] wdata_i,
  input  logic [31:0] wmask_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] rdata_o,
  output logic        dma_start_o,
  output logic        dma_to_local_o,
  output logic [12:0] dma_local_addr_o,
  output logic [23:0] dma_dram_addr_o,
  output logic [12:0] dma_row_bytes_o,
  output logic [8:0]  dma_rows_o,
  output logic [11:0] dma_row_skip_o,
  output logic        irq_raise_o,
  output logic        irq_clear_o
);

  // Command and status groups between the sequencer and the datapath.
  cdsr_pkg::dp_cmd_t dp_cmd;
  cdsr_pkg::dp_sts_t dp_sts;

  // The sequencer owns both handshakes and steps the datapath through
  // load, execute, and for a started transfer the multiply and update steps.
  cdsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // The datapath holds every architectural register, the transfer queue and
  // the result register, which stays stable while the result is stalled.
  cdsr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .sts_o            (dp_sts),
    .cmd_in_i         (cmd_i),
    .reg_index_i      (reg_index_i),
    .wdata_i          (wdata_i),
    .wmask_i          (wmask_i),
    .rdata_o          (rdata_o),
    .dma_start_o      (dma_start_o),
    .dma_to_local_o   (dma_to_local_o),
    .dma_local_addr_o (dma_local_addr_o),
    .dma_dram_addr_o  (dma_dram_addr_o),
    .dma_row_bytes_o  (dma_row_bytes_o),
    .dma_rows_o       (dma_rows_o),
    .dma_row_skip_o   (dma_row_skip_o),
    .irq_raise_o      (irq_raise_o),
    .irq_clear_o      (irq_clear_o)
  );

endmodule
